[hw/rtl/nwp_pkg.sv]
package nwp_pkg;

    localparam int MAX_LEN   = 64;
    localparam int ALPHABET  = 26;
    localparam int LET_W     = 5;
    localparam int ADDR_W    = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int LEN_W     = $clog2(MAX_LEN + 1);
    localparam int CNT_W     = LEN_W;
    localparam int CIDX_W    = $clog2(ALPHABET);
    localparam int MEM_DEPTH = 2 * (2 ** ADDR_W);
    localparam int QDEPTH    = 2;
    localparam int QPTR_W    = 1;
    localparam int QCNT_W    = 2;

    typedef struct packed {
        logic [LEN_W-1:0] len;
        logic             ovf;
    } t_desc;

    typedef struct packed {
        logic              en;
        logic [ADDR_W:0]   addr;
    } t_rd_req;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_PIVOT,
        ST_SEL,
        ST_CPRD,
        ST_CPOUT,
        ST_SELOUT,
        ST_CNT
    } t_state;

endpackage

[hw/rtl/nwp_front.sv]
module nwp_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [nwp_pkg::LET_W-1:0]     i_letter,
    input  logic                          i_word_end,
    input  logic                          i_q_full,
    output logic                          o_push,
    output nwp_pkg::t_desc                o_desc,
    input  nwp_pkg::t_rd_req              i_rd,
    output logic [nwp_pkg::LET_W-1:0]     o_rd_data
);

    logic [nwp_pkg::LET_W-1:0]  mem [nwp_pkg::MEM_DEPTH];
    logic [nwp_pkg::LEN_W-1:0]  r_len;
    logic                       r_ovf;
    logic                       r_wbank;
    logic [nwp_pkg::LET_W-1:0]  r_rd_data;
    logic                       accept;
    logic                       wr;
    logic [nwp_pkg::LET_W-1:0]  let_sat;
    logic [nwp_pkg::ADDR_W:0]   waddr;

    assign o_ready   = !i_q_full;
    assign accept    = i_valid && o_ready;
    assign wr        = accept && (r_len < nwp_pkg::LEN_W'(nwp_pkg::MAX_LEN));
    assign let_sat   = ({1'b0, i_letter} >= (nwp_pkg::LET_W + 1)'(nwp_pkg::ALPHABET)) ?
                       nwp_pkg::LET_W'(nwp_pkg::ALPHABET - 1) : i_letter;
    assign waddr     = {r_wbank, r_len[nwp_pkg::ADDR_W-1:0]};
    assign o_push    = accept && i_word_end;
    assign o_desc.len = wr ? nwp_pkg::LEN_W'(r_len + 1'b1) : r_len;
    assign o_desc.ovf = r_ovf || !wr;
    assign o_rd_data = r_rd_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len   <= '0;
            r_ovf   <= 1'b0;
            r_wbank <= 1'b0;
        end else if (o_push) begin
            r_len   <= '0;
            r_ovf   <= 1'b0;
            r_wbank <= !r_wbank;
        end else if (accept) begin
            if (wr) begin
                r_len <= nwp_pkg::LEN_W'(r_len + 1'b1);
            end else begin
                r_ovf <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            mem[waddr] <= let_sat;
        end
        if (i_rd.en) begin
            r_rd_data <= mem[i_rd.addr];
        end
    end

endmodule

[hw/rtl/nwp_queue.sv]
module nwp_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  nwp_pkg::t_desc     i_desc,
    input  logic               i_pop,
    output logic               o_valid,
    output logic               o_full,
    output nwp_pkg::t_desc     o_desc
);

    nwp_pkg::t_desc               r_ent [nwp_pkg::QDEPTH];
    logic [nwp_pkg::QPTR_W-1:0]   r_wp;
    logic [nwp_pkg::QPTR_W-1:0]   r_rp;
    logic [nwp_pkg::QCNT_W-1:0]   r_cnt;
    logic                         do_push;
    logic                         do_pop;

    assign o_valid = (r_cnt != '0);
    assign o_full  = (r_cnt == nwp_pkg::QCNT_W'(nwp_pkg::QDEPTH));
    assign o_desc  = r_ent[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= nwp_pkg::QPTR_W'(r_wp + 1'b1);
            end
            if (do_pop) begin
                r_rp <= nwp_pkg::QPTR_W'(r_rp + 1'b1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= nwp_pkg::QCNT_W'(r_cnt + 1'b1);
            end else if (do_pop && !do_push) begin
                r_cnt <= nwp_pkg::QCNT_W'(r_cnt - 1'b1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_ent[r_wp] <= i_desc;
        end
    end

endmodule

[hw/rtl/nwp_back.sv]
module nwp_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_valid,
    input  nwp_pkg::t_desc                i_q_desc,
    output logic                          o_q_pop,
    output nwp_pkg::t_rd_req              o_rd,
    input  logic [nwp_pkg::LET_W-1:0]     i_rd_data,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [nwp_pkg::LET_W-1:0]     o_letter,
    output logic                          o_end,
    output logic                          o_unch,
    output logic                          o_ovf
);

    nwp_pkg::t_state                 r_state;
    nwp_pkg::t_state                 n_state;
    logic                            r_bank;
    logic [nwp_pkg::LEN_W-1:0]       r_n;
    logic                            r_ovf;
    logic [nwp_pkg::ADDR_W-1:0]      r_k;
    logic                            r_have_prev;
    logic [nwp_pkg::LET_W-1:0]       r_prev;
    logic [nwp_pkg::ADDR_W-1:0]      r_piv;
    logic [nwp_pkg::LET_W-1:0]       r_pv;
    logic [nwp_pkg::CIDX_W-1:0]      r_j;
    logic [nwp_pkg::CIDX_W-1:0]      r_sel;
    logic [nwp_pkg::LEN_W-1:0]       r_pos;
    logic [nwp_pkg::LEN_W-1:0]       r_lim;
    logic                            r_unch;
    logic [nwp_pkg::CNT_W-1:0]       r_cnt [nwp_pkg::ALPHABET];
    logic [nwp_pkg::ALPHABET-1:0]    r_cvld;
    logic                            r_ovld;
    logic [nwp_pkg::LET_W-1:0]       r_oletter;
    logic                            r_oend;
    logic                            r_ounch;
    logic                            r_oovf;

    logic                            out_free;
    logic                            d_lt;
    logic                            k_zero;
    logic                            pos_last;
    logic                            cp_last;
    logic                            cnt_nz;
    logic [nwp_pkg::CNT_W-1:0]       cnt_rd;
    logic [nwp_pkg::CIDX_W-1:0]      cnt_addr;
    logic                            cnt_inc;
    logic                            cnt_dec;
    logic                            cnt_clr;
    logic                            emit;
    logic [nwp_pkg::LET_W-1:0]       e_letter;
    logic                            e_end;
    logic [nwp_pkg::ADDR_W-1:0]      first_idx;

    assign out_free  = !r_ovld || i_ready;
    assign d_lt      = (i_rd_data < r_prev);
    assign k_zero    = (r_k == '0);
    assign pos_last  = (r_pos == nwp_pkg::LEN_W'(r_n - 1'b1));
    assign cp_last   = (nwp_pkg::LEN_W'(r_pos + 1'b1) == r_lim);
    assign cnt_rd    = r_cvld[cnt_addr] ? r_cnt[cnt_addr] : '0;
    assign cnt_nz    = (cnt_rd != '0);
    assign first_idx = nwp_pkg::ADDR_W'(i_q_desc.len - 1'b1);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            nwp_pkg::ST_IDLE: begin
                if (i_q_valid) begin
                    n_state = nwp_pkg::ST_SCAN;
                end
            end
            nwp_pkg::ST_SCAN: begin
                if (r_have_prev && d_lt) begin
                    n_state = nwp_pkg::ST_PIVOT;
                end else if (k_zero) begin
                    n_state = nwp_pkg::ST_CPRD;
                end
            end
            nwp_pkg::ST_PIVOT: begin
                n_state = nwp_pkg::ST_SEL;
            end
            nwp_pkg::ST_SEL: begin
                if (cnt_nz) begin
                    n_state = (r_piv == '0) ? nwp_pkg::ST_SELOUT : nwp_pkg::ST_CPRD;
                end
            end
            nwp_pkg::ST_CPRD: begin
                n_state = nwp_pkg::ST_CPOUT;
            end
            nwp_pkg::ST_CPOUT: begin
                if (out_free) begin
                    if (cp_last) begin
                        n_state = r_unch ? nwp_pkg::ST_IDLE : nwp_pkg::ST_SELOUT;
                    end else begin
                        n_state = nwp_pkg::ST_CPRD;
                    end
                end
            end
            nwp_pkg::ST_SELOUT: begin
                if (out_free) begin
                    n_state = nwp_pkg::ST_CNT;
                end
            end
            nwp_pkg::ST_CNT: begin
                if (cnt_nz && out_free && pos_last) begin
                    n_state = nwp_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = nwp_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_rd     = '0;
        cnt_addr = r_j;
        cnt_inc  = 1'b0;
        cnt_dec  = 1'b0;
        cnt_clr  = 1'b0;
        emit     = 1'b0;
        e_letter = nwp_pkg::LET_W'(r_sel);
        e_end    = 1'b0;
        o_q_pop  = 1'b0;
        unique case (r_state)
            nwp_pkg::ST_IDLE: begin
                if (i_q_valid) begin
                    o_rd.en   = 1'b1;
                    o_rd.addr = {r_bank, first_idx};
                    cnt_clr   = 1'b1;
                end
            end
            nwp_pkg::ST_SCAN: begin
                o_rd.en   = 1'b1;
                o_rd.addr = {r_bank, nwp_pkg::ADDR_W'(r_k - 1'b1)};
                if (r_have_prev) begin
                    cnt_addr = r_prev[nwp_pkg::CIDX_W-1:0];
                    cnt_inc  = 1'b1;
                end
            end
            nwp_pkg::ST_PIVOT: begin
                cnt_addr = r_pv[nwp_pkg::CIDX_W-1:0];
                cnt_inc  = 1'b1;
            end
            nwp_pkg::ST_SEL: begin
                cnt_dec = cnt_nz;
            end
            nwp_pkg::ST_CPRD: begin
                o_rd.en   = 1'b1;
                o_rd.addr = {r_bank, r_pos[nwp_pkg::ADDR_W-1:0]};
            end
            nwp_pkg::ST_CPOUT: begin
                if (out_free) begin
                    emit     = 1'b1;
                    e_letter = i_rd_data;
                    e_end    = r_unch && pos_last;
                    o_q_pop  = cp_last && r_unch;
                end
            end
            nwp_pkg::ST_SELOUT: begin
                if (out_free) begin
                    emit  = 1'b1;
                    e_end = pos_last;
                end
            end
            nwp_pkg::ST_CNT: begin
                if (cnt_nz && out_free) begin
                    emit     = 1'b1;
                    e_letter = nwp_pkg::LET_W'(r_j);
                    e_end    = pos_last;
                    cnt_dec  = 1'b1;
                    o_q_pop  = pos_last;
                end
            end
            default: begin
                o_rd = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= nwp_pkg::ST_IDLE;
            r_bank  <= 1'b0;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_q_pop) begin
                r_bank <= !r_bank;
            end
            if (emit) begin
                r_ovld <= 1'b1;
            end else if (i_ready) begin
                r_ovld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_oletter <= e_letter;
            r_oend    <= e_end;
            r_ounch   <= r_unch;
            r_oovf    <= r_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cvld <= '0;
        end else if (cnt_clr) begin
            r_cvld <= '0;
        end else if (cnt_inc || cnt_dec) begin
            r_cvld[cnt_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (cnt_inc) begin
            r_cnt[cnt_addr] <= nwp_pkg::CNT_W'(cnt_rd + 1'b1);
        end else if (cnt_dec) begin
            r_cnt[cnt_addr] <= nwp_pkg::CNT_W'(cnt_rd - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            nwp_pkg::ST_IDLE: begin
                if (i_q_valid) begin
                    r_n         <= i_q_desc.len;
                    r_ovf       <= i_q_desc.ovf;
                    r_k         <= first_idx;
                    r_have_prev <= 1'b0;
                    r_pos       <= '0;
                end
            end
            nwp_pkg::ST_SCAN: begin
                if (r_have_prev && d_lt) begin
                    r_piv <= r_k;
                    r_pv  <= i_rd_data;
                end else if (k_zero) begin
                    r_unch <= 1'b1;
                    r_lim  <= r_n;
                    r_pos  <= '0;
                end else begin
                    r_prev      <= i_rd_data;
                    r_k         <= nwp_pkg::ADDR_W'(r_k - 1'b1);
                    r_have_prev <= 1'b1;
                end
            end
            nwp_pkg::ST_PIVOT: begin
                r_j <= nwp_pkg::CIDX_W'(r_pv + 1'b1);
            end
            nwp_pkg::ST_SEL: begin
                if (cnt_nz) begin
                    r_sel  <= r_j;
                    r_unch <= 1'b0;
                    r_lim  <= nwp_pkg::LEN_W'(r_piv);
                    r_pos  <= '0;
                end else begin
                    r_j <= nwp_pkg::CIDX_W'(r_j + 1'b1);
                end
            end
            nwp_pkg::ST_CPOUT: begin
                if (out_free) begin
                    r_pos <= nwp_pkg::LEN_W'(r_pos + 1'b1);
                end
            end
            nwp_pkg::ST_SELOUT: begin
                if (out_free) begin
                    r_pos <= nwp_pkg::LEN_W'(r_pos + 1'b1);
                    r_j   <= '0;
                end
            end
            nwp_pkg::ST_CNT: begin
                if (!cnt_nz) begin
                    r_j <= nwp_pkg::CIDX_W'(r_j + 1'b1);
                end else if (out_free) begin
                    r_pos <= nwp_pkg::LEN_W'(r_pos + 1'b1);
                end
            end
            default: begin
                r_pos <= r_pos;
            end
        endcase
    end

    assign o_valid  = r_ovld;
    assign o_letter = r_oletter;
    assign o_end    = r_oend;
    assign o_unch   = r_ounch;
    assign o_ovf    = r_oovf;

endmodule

[hw/rtl/next_word_permutation.sv]
// Letters load at one per cycle while the word queue has room, into one of two word banks;
// a word-end transaction queues the word for the back end, which works while the next loads.
// Back end per word, pivot p: start, scan from the end down to p, pivot, select search over
// codes above the pivot letter, read and output per prefix letter, then the selected letter
// and the rest in ascending code order; no descent: start, scan, read and emit each letter.
// Reset (i_rst_n low, synchronous) clears control state; the word store is not cleared.
module next_word_permutation (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [nwp_pkg::LET_W-1:0]     i_letter,
    input  logic                          i_word_end,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [nwp_pkg::LET_W-1:0]     o_out_letter,
    output logic                          o_out_end,
    output logic                          o_unchanged,
    output logic                          o_overflow
);

    logic                          q_push;
    logic                          q_pop;
    logic                          q_valid;
    logic                          q_full;
    nwp_pkg::t_desc                push_desc;
    nwp_pkg::t_desc                head_desc;
    nwp_pkg::t_rd_req              rd;
    logic [nwp_pkg::LET_W-1:0]     rd_data;

    nwp_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_letter   (i_letter),
        .i_word_end (i_word_end),
        .i_q_full   (q_full),
        .o_push     (q_push),
        .o_desc     (push_desc),
        .i_rd       (rd),
        .o_rd_data  (rd_data)
    );

    nwp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_desc  (push_desc),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_desc  (head_desc)
    );

    nwp_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_desc  (head_desc),
        .o_q_pop   (q_pop),
        .o_rd      (rd),
        .i_rd_data (rd_data),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_letter  (o_out_letter),
        .o_end     (o_out_end),
        .o_unch    (o_unchanged),
        .o_ovf     (o_overflow)
    );

`ifndef SYNTH
    a_pop_needs_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid)
        else $error("word queue popped while empty");

    a_push_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full)
        else $error("word queue pushed while full");

    a_pop_shows_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |=> (o_valid && o_out_end))
        else $error("word retired without a marked final letter");
`endif

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

    localparam int  WATCHDOG_LIMIT = 3000;
    localparam int  DRAIN_CYCLES   = 300;
    localparam int  ITEM_TARGET    = 270;
    localparam int  MAX_PRINTS     = 30;
    localparam byte CHAR_A         = "A";

    typedef struct packed {
        logic [nwp_pkg::LET_W-1:0] code;
        logic                      last;
    } t_letter_item;

    typedef struct packed {
        logic [nwp_pkg::LET_W-1:0] code;
        logic                      last;
        logic                      unch;
        logic                      ovf;
    } t_perm_letter;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n;
    logic                      i_valid;
    logic                      o_ready;
    logic [nwp_pkg::LET_W-1:0] i_letter;
    logic                      i_word_end;
    logic                      o_valid;
    logic                      i_ready;
    logic [nwp_pkg::LET_W-1:0] o_out_letter;
    logic                      o_out_end;
    logic                      o_unchanged;
    logic                      o_overflow;

    next_word_permutation dut (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    t_letter_item     letter_feed[$];
    t_perm_letter     perm_expected[$];
    int               word_buf[$];
    t_letter_item     cur_item;

    logic [nwp_pkg::LET_W-1:0] word_mem[nwp_pkg::MAX_LEN];
    int               word_len = 0;
    bit               ovf_seen = 1'b0;

    int  errors = 0;
    int  feed_items = 0;
    int  words_done = 0;
    int  unchanged_words = 0;
    int  overflow_words = 0;
    int  results_checked = 0;
    int  idle_cycles = 0;
    bit  letter_taken = 1'b0;
    int  feed_gap = 0;
    int  stall_left = 0;
    bit  feed_calm = 1'b0;
    bit  sink_calm = 1'b0;
    int  feed_calm_left = 20;
    int  sink_calm_left = 35;

    function automatic int pick_gap(input bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    task automatic push_expected(input int code, input bit last, input bit unch, input bit ovf);
        t_perm_letter e;
        e.code = nwp_pkg::LET_W'(code);
        e.last = last;
        e.unch = unch;
        e.ovf  = ovf;
        perm_expected.push_back(e);
    endtask

    task automatic predict_next_perm(input logic [nwp_pkg::LET_W-1:0] code, input logic last);
        logic [nwp_pkg::LET_W-1:0] c;
        int               counts[nwp_pkg::ALPHABET];
        int               n, k, j, pivot, pos, pv;
        c = (code >= nwp_pkg::ALPHABET) ? nwp_pkg::LET_W'(nwp_pkg::ALPHABET - 1) : code;
        if (word_len < nwp_pkg::MAX_LEN) begin
            word_mem[word_len] = c;
            word_len++;
        end else begin
            ovf_seen = 1'b1;
        end
        if (!last)
            return;
        for (j = 0; j < nwp_pkg::ALPHABET; j++)
            counts[j] = 0;
        n = word_len;
        pivot = -1;
        for (k = n - 1; k >= 1; k--) begin
            counts[word_mem[k]]++;
            if (word_mem[k-1] < word_mem[k]) begin
                pivot = k - 1;
                break;
            end
        end
        words_done++;
        if (ovf_seen)
            overflow_words++;
        if (pivot < 0) begin
            unchanged_words++;
            for (k = 0; k < n; k++)
                push_expected(word_mem[k], k == n - 1, 1'b1, ovf_seen);
        end else begin
            for (k = 0; k < pivot; k++)
                push_expected(word_mem[k], 1'b0, 1'b0, ovf_seen);
            pos = pivot;
            pv = word_mem[pivot];
            counts[pv]++;
            for (j = pv + 1; j < nwp_pkg::ALPHABET; j++) begin
                if (counts[j] > 0) begin
                    counts[j]--;
                    push_expected(j, pos == n - 1, 1'b0, ovf_seen);
                    pos++;
                    break;
                end
            end
            for (j = 0; j < nwp_pkg::ALPHABET; j++) begin
                while (counts[j] > 0 && pos < n) begin
                    counts[j]--;
                    push_expected(j, pos == n - 1, 1'b0, ovf_seen);
                    pos++;
                end
            end
        end
        word_len = 0;
        ovf_seen = 1'b0;
    endtask

    task automatic report(input string field, input int want, input int got);
        errors++;
        if (errors <= MAX_PRINTS)
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    endtask

    task automatic check_result();
        t_perm_letter want;
        if (perm_expected.size() == 0) begin
            errors++;
            if (errors <= MAX_PRINTS)
                $display("%0t: unexpected result, expected none, actual letter %0d end %0b",
                         $time, o_out_letter, o_out_end);
            return;
        end
        want = perm_expected.pop_front();
        results_checked++;
        if (o_out_letter !== want.code)
            report("out_letter", want.code, o_out_letter);
        if (o_out_end !== want.last)
            report("out_end", want.last, o_out_end);
        if (o_unchanged !== want.unch)
            report("unchanged", want.unch, o_unchanged);
        if (o_overflow !== want.ovf)
            report("overflow", want.ovf, o_overflow);
    endtask

    task automatic queue_word();
        t_letter_item it;
        foreach (word_buf[k]) begin
            it.code = nwp_pkg::LET_W'(word_buf[k]);
            it.last = (k == word_buf.size() - 1);
            letter_feed.push_back(it);
        end
        feed_items += word_buf.size();
        word_buf.delete();
    endtask

    task automatic add_text(input string s);
        for (int k = 0; k < s.len(); k++)
            word_buf.push_back(s[k] - CHAR_A);
        queue_word();
    endtask

    // monitor: predict on accepted letters, check accepted results, watchdog
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            letter_taken <= 1'b0;
            idle_cycles <= 0;
        end else begin
            letter_taken <= i_valid && o_ready;
            if (i_valid && o_ready)
                predict_next_perm(i_letter, i_word_end);
            if (o_valid && i_ready)
                check_result();
            if ((i_valid && o_ready) || (o_valid && i_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: watchdog expired, %0d results outstanding",
                         $time, perm_expected.size());
                $display("simulation failed");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // alternate calm stretches with stretches of random gaps
    always @(negedge i_clk) begin
        if (feed_calm_left == 0) begin
            feed_calm <= !feed_calm;
            feed_calm_left <= $urandom_range(10, 60);
        end else begin
            feed_calm_left <= feed_calm_left - 1;
        end
        if (sink_calm_left == 0) begin
            sink_calm <= !sink_calm;
            sink_calm_left <= $urandom_range(10, 60);
        end else begin
            sink_calm_left <= sink_calm_left - 1;
        end
    end

    // driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (i_valid && !letter_taken) begin
            // hold until the transaction completes
        end else if (feed_gap != 0) begin
            i_valid <= 1'b0;
            feed_gap <= feed_gap - 1;
        end else if (letter_feed.size() != 0) begin
            cur_item = letter_feed.pop_front();
            i_letter <= cur_item.code;
            i_word_end <= cur_item.last;
            i_valid <= 1'b1;
            feed_gap <= pick_gap(feed_calm);
        end else begin
            i_valid <= 1'b0;
        end
    end

    // result sink
    always @(negedge i_clk) begin
        if (stall_left != 0) begin
            i_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            i_ready <= 1'b1;
            stall_left <= pick_gap(sink_calm);
        end
    end

    initial begin
        int kind, len, base, prev, long_words;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_letter = '0;
        i_word_end = 1'b0;
        i_ready = 1'b0;
        long_words = 0;

        add_text("A");
        add_text("AB");
        add_text("BA");
        add_text("ABDC");
        add_text("BAA");
        add_text("AABB");
        add_text("ZZZ");
        add_text("ACB");
        word_buf = '{31, 0, 26};
        queue_word();
        word_buf = '{25, 30};
        queue_word();

        while (feed_items < ITEM_TARGET) begin
            kind = $urandom_range(0, 99);
            if ((long_words == 0 && feed_items > 60) || (long_words == 1 && feed_items > 170)) begin
                len = (long_words == 0) ? nwp_pkg::MAX_LEN + $urandom_range(1, 8)
                                        : nwp_pkg::MAX_LEN - $urandom_range(0, 1);
                base = $urandom_range(0, 20);
                repeat (len)
                    word_buf.push_back(base + $urandom_range(0, 5));
                long_words++;
            end else if (kind < 50) begin
                base = $urandom_range(0, 22);
                repeat ($urandom_range(1, 8))
                    word_buf.push_back(base + $urandom_range(0, 3));
            end else if (kind < 65) begin
                prev = $urandom_range(3, 25);
                repeat ($urandom_range(2, 6)) begin
                    word_buf.push_back(prev);
                    prev = prev - $urandom_range(0, 3);
                    if (prev < 0)
                        prev = 0;
                end
            end else if (kind < 85) begin
                repeat ($urandom_range(1, 6))
                    word_buf.push_back($urandom_range(0, 31));
            end else begin
                repeat ($urandom_range(1, 10))
                    word_buf.push_back($urandom_range(0, nwp_pkg::ALPHABET - 1));
            end
            queue_word();
        end

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (letter_feed.size() != 0 || i_valid || perm_expected.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d letters in %0d words: %0d already greatest, %0d over capacity",
                 feed_items, words_done, unchanged_words, overflow_words);
        $display("checked %0d result letters, %0d mismatches", results_checked, errors);
        if (errors == 0 && perm_expected.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
